// File: rtl/core/salc_pkg.sv
// Shared types and codes for the set-associative LRU cache tag store.
`default_nettype none
package salc_pkg;

	// Access kinds carried by a request
	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_STORE  = 2'd1;
	localparam logic [1:0] MODE_MODIFY = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	// Register map: index is paddr[3:2]
	localparam int          PADDR_W         = 4;
	localparam logic [1:0]  REG_SET_BITS    = 2'd0;
	localparam logic [1:0]  REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0]  REG_ACTIVE_WAYS = 2'd2;

	localparam logic [2:0]  SET_BITS_RST    = 3'd0;
	localparam logic [5:0]  OFFSET_BITS_RST = 6'd0;
	localparam logic [2:0]  ACTIVE_WAYS_RST = 3'd4;

	typedef struct packed {
		logic [2:0] set_index_bits;
		logic [5:0] offset_bits;
		logic [2:0] active_ways;
	} cfg_t;

	typedef struct packed {
		logic hit;
		logic evict;
	} lookup_t;

endpackage
`default_nettype wire

// File: rtl/core/salc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/core/salc_cfg.sv
// APB configuration registers of the cache tag store.
`default_nettype none
module salc_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [salc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output salc_pkg::cfg_t                   cfg
);
	import salc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_index_bits <= SET_BITS_RST;
			cfg_q.offset_bits    <= OFFSET_BITS_RST;
			cfg_q.active_ways    <= ACTIVE_WAYS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SET_BITS:    cfg_q.set_index_bits <= pwdata[2:0];
				REG_OFFSET_BITS: cfg_q.offset_bits    <= pwdata[5:0];
				REG_ACTIVE_WAYS: cfg_q.active_ways    <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SET_BITS:    prdata = {29'd0, cfg_q.set_index_bits};
			REG_OFFSET_BITS: prdata = {26'd0, cfg_q.offset_bits};
			REG_ACTIVE_WAYS: prdata = {29'd0, cfg_q.active_ways};
			default:         prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/core/salc_way_sel.sv
// Hit search, victim choice and LRU rank update for one set.
`default_nettype none
module salc_way_sel #(
	parameter int WAYS       = 4,
	parameter int ADDR_WIDTH = 64,
	parameter int RANK_W     = 2,
	parameter int NW_W       = 3
) (
	input  wire logic [WAYS-1:0]            row_vld,
	input  wire logic [WAYS*ADDR_WIDTH-1:0] row_tags,
	input  wire logic [WAYS*RANK_W-1:0]     row_rank,
	input  wire logic [ADDR_WIDTH-1:0]      tag,
	input  wire logic [NW_W-1:0]            nw,
	output salc_pkg::lookup_t               res,
	output logic      [RANK_W-1:0]          way,
	output logic      [WAYS*RANK_W-1:0]     new_rank
);
	import salc_pkg::*;

	logic              hit_found;
	logic [RANK_W-1:0] hit_way;
	logic              inv_found;
	logic [RANK_W-1:0] inv_way;
	logic [RANK_W-1:0] lru_way;
	logic [RANK_W-1:0] lru_min;
	logic [RANK_W-1:0] old_rank;
	logic [RANK_W-1:0] cur_rank;

	// Lowest matching way, lowest invalid way, lowest-ranked active way
	always_comb begin
		hit_found = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		lru_way   = '0;
		lru_min   = row_rank[RANK_W-1:0];
		for (int i = 0; i < WAYS; i++) begin
			if (int'(nw) > i) begin
				if (!hit_found && row_vld[i] &&
				    row_tags[i*ADDR_WIDTH +: ADDR_WIDTH] == tag) begin
					hit_found = 1'b1;
					hit_way   = RANK_W'(i);
				end
				if (!inv_found && !row_vld[i]) begin
					inv_found = 1'b1;
					inv_way   = RANK_W'(i);
				end
				if (i > 0 && row_rank[i*RANK_W +: RANK_W] < lru_min) begin
					lru_min = row_rank[i*RANK_W +: RANK_W];
					lru_way = RANK_W'(i);
				end
			end
		end
	end

	always_comb begin
		res.hit   = hit_found;
		res.evict = !hit_found && !inv_found;
		priority if (hit_found) begin
			way = hit_way;
		end else if (inv_found) begin
			way = inv_way;
		end else begin
			way = lru_way;
		end
	end

	// Touched way goes to the top; those above its old rank drop by one
	always_comb begin
		old_rank = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (way == RANK_W'(i)) begin
				old_rank = row_rank[i*RANK_W +: RANK_W];
			end
		end
		new_rank = '0;
		for (int i = 0; i < WAYS; i++) begin
			cur_rank = row_rank[i*RANK_W +: RANK_W];
			if (way == RANK_W'(i)) begin
				new_rank[i*RANK_W +: RANK_W] = RANK_W'(WAYS - 1);
			end else if (cur_rank > old_rank) begin
				new_rank[i*RANK_W +: RANK_W] = cur_rank - RANK_W'(1);
			end else begin
				new_rank[i*RANK_W +: RANK_W] = cur_rank;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/set_assoc_lru_cache_tags.sv
// Top level of the set-associative LRU cache tag store.
`default_nettype none
// A request (start high while busy is low) carries a mode and a byte address. Load and
// store give one result; modify gives two, the second marked by last. Results appear on
// the result ports for one cycle with done high, and cannot be held off. A load or store
// passes through the lookup stage once, so one can be accepted every cycle while busy is
// low; a modify holds busy high while its first access is in the lookup stage, because
// its second access reads back the set row written by the first. Mode 3 is accepted and
// dropped. The set row is read from RAM at the request edge as the request enters the
// lookup stage, is looked up and written back in the following cycle, and the result is
// registered at the output. No clearing pass: per-set valid bits reset at once. Config
// is written over APB only while the block is idle; the user keeps to it, not the block.
module set_assoc_lru_cache_tags #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS         = 4,
	parameter int ADDR_WIDTH   = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   mode,
	input  wire logic [ADDR_WIDTH-1:0]        address,
	output logic                              done,
	output logic                              hit,
	output logic                              evicted,
	output logic                              last,
	output logic      [31:0]                  hit_total,
	output logic      [31:0]                  miss_total,
	output logic      [31:0]                  eviction_total,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [salc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);
	import salc_pkg::*;

	localparam int SET_W    = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SB_W     = MAX_SET_BITS > 0 ? $clog2(MAX_SET_BITS + 1) : 1;
	localparam int RANK_W   = WAYS > 1 ? $clog2(WAYS) : 1;
	localparam int NW_W     = $clog2(WAYS + 1);
	localparam int TROW_W   = WAYS * ADDR_WIDTH;
	localparam int RROW_W   = WAYS * RANK_W;

	cfg_t cfg;

	salc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Address split
	logic [SB_W-1:0]       sb_eff;
	logic [6:0]            tag_shift;
	logic [ADDR_WIDTH-1:0] off_shifted;
	logic [SET_W-1:0]      set_mask;
	logic [SET_W-1:0]      set_in;
	logic [ADDR_WIDTH-1:0] tag_in;
	logic [NW_W-1:0]       nw;

	assign sb_eff      = (int'(cfg.set_index_bits) > MAX_SET_BITS) ?
	                     SB_W'(MAX_SET_BITS) : SB_W'(cfg.set_index_bits);
	assign tag_shift   = {1'b0, cfg.offset_bits} + 7'(sb_eff);
	assign off_shifted = address >> cfg.offset_bits;
	assign set_mask    = ~({SET_W{1'b1}} << sb_eff);
	assign set_in      = off_shifted[SET_W-1:0] & set_mask;
	assign tag_in      = address >> tag_shift;

	always_comb begin
		if (cfg.active_ways == 3'd0) begin
			nw = NW_W'(1);
		end else if (int'(cfg.active_ways) > WAYS) begin
			nw = NW_W'(WAYS);
		end else begin
			nw = NW_W'(cfg.active_ways);
		end
	end

	// Request acceptance and lookup stage control
	logic                  accept;
	logic                  act_s1;
	logic                  mod_s1;
	logic                  first_s1;
	logic [SET_W-1:0]      set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;
	logic                  second_due;

	assign second_due = act_s1 && mod_s1 && first_s1;
	assign busy       = second_due;
	assign accept     = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1   <= 1'b0;
			mod_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else if (second_due) begin
			first_s1 <= 1'b0;
		end else if (accept && mode != MODE_NONE) begin
			act_s1   <= 1'b1;
			mod_s1   <= (mode == MODE_MODIFY);
			first_s1 <= 1'b1;
		end else begin
			act_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !second_due) begin
			set_s1 <= set_in;
			tag_s1 <= tag_in;
		end
	end

	// Set row storage
	logic [TROW_W-1:0] tag_rdata;
	logic [RROW_W-1:0] rank_rdata;
	logic [TROW_W-1:0] tag_wdata;
	logic [RROW_W-1:0] rank_wdata;
	logic [WAYS-1:0]   vld_q [NUM_SETS];

	salc_ram #(.WIDTH(TROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
		.clk   (clk),
		.we    (act_s1),
		.waddr (set_s1),
		.wdata (tag_wdata),
		.raddr (set_in),
		.rdata (tag_rdata)
	);

	salc_ram #(.WIDTH(RROW_W), .DEPTH(NUM_SETS)) u_rank_ram (
		.clk   (clk),
		.we    (act_s1),
		.waddr (set_s1),
		.wdata (rank_wdata),
		.raddr (set_in),
		.rdata (rank_rdata)
	);

	// Row written on the previous edge, for a read that raced it
	logic              byp_vld_q;
	logic [SET_W-1:0]  byp_set_q;
	logic [TROW_W-1:0] byp_tags_q;
	logic [RROW_W-1:0] byp_rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_vld_q <= 1'b0;
		end else begin
			byp_vld_q <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		byp_set_q  <= set_s1;
		byp_tags_q <= tag_wdata;
		byp_rank_q <= rank_wdata;
	end

	logic [WAYS-1:0]   row_vld;
	logic              use_byp;
	logic [TROW_W-1:0] row_tags;
	logic [RROW_W-1:0] row_rank;
	logic [RROW_W-1:0] rst_rank;
	logic [RROW_W-1:0] new_rank;
	logic [RANK_W-1:0] way;
	lookup_t           lk;

	assign row_vld = vld_q[set_s1];
	assign use_byp = byp_vld_q && (byp_set_q == set_s1);

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			rst_rank[i*RANK_W +: RANK_W] = RANK_W'(i);
		end
	end

	// A set that was never filled still holds the reset ranking
	always_comb begin
		priority if (use_byp) begin
			row_tags = byp_tags_q;
			row_rank = byp_rank_q;
		end else if (|row_vld) begin
			row_tags = tag_rdata;
			row_rank = rank_rdata;
		end else begin
			row_tags = tag_rdata;
			row_rank = rst_rank;
		end
	end

	salc_way_sel #(
		.WAYS       (WAYS),
		.ADDR_WIDTH (ADDR_WIDTH),
		.RANK_W     (RANK_W),
		.NW_W       (NW_W)
	) u_way_sel (
		.row_vld  (row_vld),
		.row_tags (row_tags),
		.row_rank (row_rank),
		.tag      (tag_s1),
		.nw       (nw),
		.res      (lk),
		.way      (way),
		.new_rank (new_rank)
	);

	always_comb begin
		tag_wdata = row_tags;
		tag_wdata[way*ADDR_WIDTH +: ADDR_WIDTH] = tag_s1;
	end
	assign rank_wdata = new_rank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SETS; s++) begin
				vld_q[s] <= '0;
			end
		end else if (act_s1) begin
			vld_q[set_s1][way] <= 1'b1;
		end
	end

	// Results and running totals
	logic        done_q;
	logic        hit_q;
	logic        evicted_q;
	logic        last_q;
	logic [31:0] hits_q;
	logic [31:0] misses_q;
	logic [31:0] evictions_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
			evictions_q <= '0;
		end else begin
			done_q <= act_s1;
			if (act_s1) begin
				if (lk.hit && hits_q != '1) begin
					hits_q <= hits_q + 32'd1;
				end
				if (!lk.hit && misses_q != '1) begin
					misses_q <= misses_q + 32'd1;
				end
				if (lk.evict && evictions_q != '1) begin
					evictions_q <= evictions_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_s1) begin
			hit_q     <= lk.hit;
			evicted_q <= lk.evict;
			last_q    <= !second_due;
		end
	end

	assign done           = done_q;
	assign hit            = hit_q;
	assign evicted        = evicted_q;
	assign last           = last_q;
	assign hit_total      = hits_q;
	assign miss_total     = misses_q;
	assign eviction_total = evictions_q;
endmodule
`default_nettype wire

// File: tb/tb_set_assoc_lru_cache_tags.sv
// Self-checking testbench for the set-associative LRU cache tag store.
`default_nettype none
module tb_set_assoc_lru_cache_tags;
	timeunit 1ns;
	timeprecision 1ps;
	import salc_pkg::*;

	localparam int MAX_SET_BITS = 6;
	localparam int WAYS         = 4;
	localparam int SETS         = 1 << MAX_SET_BITS;
	localparam int PHASES       = 12;
	localparam int FIXED_PHASES = 8;
	localparam int PHASE_ITEMS  = 50;
	localparam int TABLE_ROWS   = 14;

	typedef struct packed {
		logic        hit;
		logic        evicted;
		logic        last;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evictions;
	} lookup_result_t;

	typedef struct packed {
		logic [1:0]     kind;
		logic [63:0]    addr;
		logic           typed;
		lookup_result_t want;
	} access_row_t;

	localparam lookup_result_t UNTYPED = '0;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [63:0] address;
	logic        done;
	logic        hit;
	logic        evicted;
	logic        last;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] eviction_total;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	set_assoc_lru_cache_tags dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.address        (address),
		.done           (done),
		.hit            (hit),
		.evicted        (evicted),
		.last           (last),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// Register settings of the predictor
	logic [2:0] cfg_set_bits;
	logic [5:0] cfg_offset_bits;
	logic [2:0] cfg_ways;

	// Tag store as the predictor sees it
	bit          line_valid [SETS][WAYS];
	logic [63:0] line_tag   [SETS][WAYS];
	int          lru_rank   [SETS][WAYS];
	logic [31:0] hits_seen;
	logic [31:0] misses_seen;
	logic [31:0] evictions_seen;

	lookup_result_t predicted_lookups [$];
	lookup_result_t due;
	int error_count;
	int results_checked;
	int requests_sent;
	int dropped_requests;
	int settings_applied;

	// At reset the store holds a single set with four ways, so the tag is the whole address
	access_row_t access_table [TABLE_ROWS] = '{
		'{MODE_LOAD,   64'h0000_0000_0000_0000, 1'b1,
			'{1'b0, 1'b0, 1'b1, 32'd0, 32'd1, 32'd0}},
		'{MODE_STORE,  64'h0000_0000_0000_0000, 1'b1,
			'{1'b1, 1'b0, 1'b1, 32'd1, 32'd1, 32'd0}},
		'{MODE_NONE,   64'h0000_0000_0000_0000, 1'b0, UNTYPED},
		'{MODE_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{1'b0, 1'b0, 1'b1, 32'd1, 32'd2, 32'd0}},
		'{MODE_MODIFY, 64'h8000_0000_0000_0000, 1'b0, UNTYPED},
		'{MODE_STORE,  64'h5555_5555_5555_5555, 1'b0, UNTYPED},
		'{MODE_LOAD,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, UNTYPED},
		'{MODE_LOAD,   64'h0000_0000_0000_0000, 1'b0, UNTYPED},
		'{MODE_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, UNTYPED},
		'{MODE_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, UNTYPED},
		'{MODE_LOAD,   64'h0000_0000_0000_0001, 1'b0, UNTYPED},
		'{MODE_STORE,  64'h8000_0000_0000_0000, 1'b0, UNTYPED},
		'{MODE_MODIFY, 64'h5555_5555_5555_5555, 1'b0, UNTYPED},
		'{MODE_STORE,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, UNTYPED}
	};

	// Fixed settings hit the extremes and the clamped values; the rest are drawn
	int fixed_set_bits [FIXED_PHASES] = '{7, 6, 3, 0, 6, 2, 1, 4};
	int fixed_offset   [FIXED_PHASES] = '{0, 58, 63, 63, 0, 4, 12, 6};
	int fixed_ways     [FIXED_PHASES] = '{0, 4, 7, 1, 5, 2, 3, 6};

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic touch_way(input int set_no, input int way);
		int old;
		old = lru_rank[set_no][way];
		for (int w = 0; w < WAYS; w++) begin
			if (lru_rank[set_no][w] > old)
				lru_rank[set_no][w]--;
		end
		lru_rank[set_no][way] = WAYS - 1;
	endtask

	// One tag lookup with fill on a miss
	task automatic cache_lookup(input logic [63:0] addr, input logic is_last,
			output lookup_result_t r);
		int sb;
		int ob;
		int nw;
		int set_no;
		int victim;
		logic [63:0] tag;
		sb = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
		ob = cfg_offset_bits;
		nw = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : cfg_ways);
		set_no = int'((addr >> ob) & ((64'd1 << sb) - 64'd1));
		tag = addr >> (ob + sb);
		victim = -1;
		r = '0;
		r.last = is_last;
		for (int w = 0; w < nw; w++) begin
			if (victim < 0 && line_valid[set_no][w] && line_tag[set_no][w] == tag)
				victim = w;
		end
		if (victim >= 0) begin
			r.hit = 1'b1;
			if (hits_seen != 32'hFFFF_FFFF)
				hits_seen++;
		end else begin
			if (misses_seen != 32'hFFFF_FFFF)
				misses_seen++;
			for (int w = 0; w < nw; w++) begin
				if (victim < 0 && !line_valid[set_no][w])
					victim = w;
			end
			if (victim < 0) begin
				victim = 0;
				for (int w = 1; w < nw; w++) begin
					if (lru_rank[set_no][w] < lru_rank[set_no][victim])
						victim = w;
				end
				r.evicted = 1'b1;
				if (evictions_seen != 32'hFFFF_FFFF)
					evictions_seen++;
			end
			line_valid[set_no][victim] = 1'b1;
			line_tag[set_no][victim] = tag;
		end
		touch_way(set_no, victim);
		r.hits = hits_seen;
		r.misses = misses_seen;
		r.evictions = evictions_seen;
	endtask

	// Drive one request, hold it until taken, then queue what it should produce
	task automatic issue_access(input logic [1:0] kind, input logic [63:0] addr,
			input int gap, input logic typed, input lookup_result_t typed_want);
		lookup_result_t fresh [2];
		int n;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= kind;
		address <= addr;
		do @(posedge clk); while (busy);
		requests_sent++;
		n = 0;
		if (kind == MODE_LOAD || kind == MODE_STORE) begin
			cache_lookup(addr, 1'b1, fresh[0]);
			n = 1;
		end else if (kind == MODE_MODIFY) begin
			cache_lookup(addr, 1'b0, fresh[0]);
			cache_lookup(addr, 1'b1, fresh[1]);
			n = 2;
		end else begin
			dropped_requests++;
		end
		if (typed && n == 1)
			predicted_lookups.push_back(typed_want);
		else
			for (int i = 0; i < n; i++)
				predicted_lookups.push_back(fresh[i]);
	endtask

	task automatic write_setting(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SET_BITS:    cfg_set_bits = value[2:0];
			REG_OFFSET_BITS: cfg_offset_bits = value[5:0];
			REG_ACTIVE_WAYS: cfg_ways = value[2:0];
			default: ;
		endcase
	endtask

	// Registers change only once the block has gone quiet
	task automatic apply_settings(input int sb, input int ob, input int nw);
		start <= 1'b0;
		while (predicted_lookups.size() != 0) @(posedge clk);
		// let the block sit idle before the registers are touched
		repeat (4) @(posedge clk);
		write_setting(REG_SET_BITS, 32'(sb));
		write_setting(REG_OFFSET_BITS, 32'(ob));
		write_setting(REG_ACTIVE_WAYS, 32'(nw));
		settings_applied++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (predicted_lookups.size() == 0) begin
				report_mismatch("unexpected result, hit", 64'(hit), 64'h0);
			end else begin
				due = predicted_lookups.pop_front();
				results_checked++;
				if (hit !== due.hit)
					report_mismatch("hit", 64'(hit), 64'(due.hit));
				if (evicted !== due.evicted)
					report_mismatch("evicted", 64'(evicted), 64'(due.evicted));
				if (last !== due.last)
					report_mismatch("last", 64'(last), 64'(due.last));
				if (hit_total !== due.hits)
					report_mismatch("hit_total", 64'(hit_total), 64'(due.hits));
				if (miss_total !== due.misses)
					report_mismatch("miss_total", 64'(miss_total), 64'(due.misses));
				if (eviction_total !== due.evictions)
					report_mismatch("eviction_total", 64'(eviction_total),
						64'(due.evictions));
			end
		end
	end

	initial begin
		#1_000_000;
		$display("TIMEOUT with %0d results outstanding", predicted_lookups.size());
		$display("tb_set_assoc_lru_cache_tags: done, errors");
		$finish;
	end

	initial begin
		logic [63:0] tag_pool [8];
		int set_pool [3];
		int pool_size;
		int sb;
		int ob;
		int nw;
		int sb_eff;
		int pick;
		int drain;
		bit steady;
		logic [1:0] kind;
		logic [63:0] addr;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_LOAD;
		address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		error_count = 0;
		results_checked = 0;
		requests_sent = 0;
		dropped_requests = 0;
		settings_applied = 0;
		cfg_set_bits = SET_BITS_RST;
		cfg_offset_bits = OFFSET_BITS_RST;
		cfg_ways = ACTIVE_WAYS_RST;
		hits_seen = '0;
		misses_seen = '0;
		evictions_seen = '0;
		for (int s = 0; s < SETS; s++)
			for (int w = 0; w < WAYS; w++) begin
				line_valid[s][w] = 1'b0;
				line_tag[s][w] = '0;
				lru_rank[s][w] = w;
			end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (access_table[i])
			issue_access(access_table[i].kind, access_table[i].addr, $urandom_range(0, 7),
				access_table[i].typed, access_table[i].want);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase < FIXED_PHASES) begin
				sb = fixed_set_bits[phase];
				ob = fixed_offset[phase];
				nw = fixed_ways[phase];
			end else begin
				sb = $urandom_range(0, 7);
				ob = $urandom_range(0, 63);
				nw = $urandom_range(0, 7);
			end
			apply_settings(sb, ob, nw);
			sb_eff = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
			// a few tags over a few sets, so lines get reused and evicted
			pool_size = $urandom_range(2, 8);
			foreach (tag_pool[i])
				tag_pool[i] = {$urandom, $urandom};
			foreach (set_pool[i])
				set_pool[i] = $urandom_range(0, SETS - 1);
			steady = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 19);
				if (pick < 2)
					kind = MODE_NONE;
				else if (pick % 3 == 0)
					kind = MODE_LOAD;
				else if (pick % 3 == 1)
					kind = MODE_STORE;
				else
					kind = MODE_MODIFY;
				if ($urandom_range(0, 6) == 0)
					addr = {$urandom, $urandom};
				else
					addr = (tag_pool[$urandom_range(0, pool_size - 1)] << (ob + sb_eff))
						| ((64'(set_pool[$urandom_range(0, 2)]) & ((64'd1 << sb_eff) - 64'd1))
							<< ob)
						| ({$urandom, $urandom} & ((64'd1 << ob) - 64'd1));
				issue_access(kind, addr, steady ? 0 : $urandom_range(0, 7), 1'b0, UNTYPED);
			end
		end

		start <= 1'b0;
		drain = 0;
		while (predicted_lookups.size() != 0 && drain < 200) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (predicted_lookups.size() != 0)
			report_mismatch("results never delivered", 64'(predicted_lookups.size()), 64'h0);

		$display("run covered %0d requests (%0d dropped), %0d results checked, %0d settings",
			requests_sent, dropped_requests, results_checked, settings_applied + 1);
		$display("lookup totals seen: %0d hits, %0d misses, %0d evictions",
			hits_seen, misses_seen, evictions_seen);
		if (error_count == 0)
			$display("tb_set_assoc_lru_cache_tags: done, clean");
		else
			$display("tb_set_assoc_lru_cache_tags: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// File: set_assoc_lru_cache_tags.f
rtl/core/salc_pkg.sv
rtl/core/salc_ram.sv
rtl/core/salc_cfg.sv
rtl/core/salc_way_sel.sv
rtl/core/set_assoc_lru_cache_tags.sv
tb/tb_set_assoc_lru_cache_tags.sv
